/* design/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// spq_pkg: types, codes and default sizes shared by the sorted priority queue
// no dependencies; imported by the interfaces and by the top module

package spq_pkg;

    // payload widths and default sizes
    localparam int VALUE_BITS    = 32;
    localparam int CAPACITY_DEF  = 16;
    localparam int TAG_BITS_DEF  = 16;
    localparam int CNT_BITS_DEF  = $clog2(CAPACITY_DEF + 1);

    // request kind
    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_POP    = 1'b1
    } kind_t;

    // response status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_PUT  = 2'd2,
        S_POP  = 2'd3
    } state_t;

endpackage

`default_nettype wire

/* design/spq_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// spq_req_if / spq_rsp_if: valid/ready channels of the sorted priority queue
// depends on spq_pkg for the kind and status codes

interface spq_req_if #(
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
);
    import spq_pkg::*;

    logic                  valid;
    logic                  ready;
    kind_t                 kind;
    logic [VALUE_BITS-1:0] entry_value;
    logic [TAG_BITS-1:0]   entry_tag;

    modport source (output valid, kind, entry_value, entry_tag, input ready);
    modport sink   (input valid, kind, entry_value, entry_tag, output ready);
endinterface

interface spq_rsp_if #(
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
    parameter int CNT_W    = spq_pkg::CNT_BITS_DEF
);
    import spq_pkg::*;

    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [VALUE_BITS-1:0] out_value;
    logic [TAG_BITS-1:0]   out_tag;
    logic [CNT_W-1:0]      count_after;

    modport source (output valid, status, out_value, out_tag, count_after, input ready);
    modport sink   (input valid, status, out_value, out_tag, count_after, output ready);
endinterface

`default_nettype wire

/* design/spq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// spq_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies

module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* design/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sorted priority queue, largest value first, newest first among equal values.
// Pop: one RAM read of the head in S_POP; the response register loads once it is free.
// Insert: straight into an empty queue, else a walk over the stored entries whose
// value is <= the new one, from the tail one per cycle through the RAM port.
// Full/empty answers load straight from idle. One request in flight; the next is
// taken the cycle after the response loads, once the response register drains.
// Reset clears state, count, ring pointers and response valid; the entry RAM is left as is.

module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    spq_req_if.sink  req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = VALUE_BITS + TAG_BITS;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0]  ONE_CNT   = CNT_W'(1);

    // ring pointer step with wrap at the capacity
    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        return (p == LAST_ADDR) ? '0 : p + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
        return (p == '0) ? LAST_ADDR : p - ADDR_W'(1);
    endfunction

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     head_reg, head_next;
    logic [ADDR_W-1:0]     tail_reg, tail_next;
    logic [ADDR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      remaining_reg, remaining_next;
    logic [VALUE_BITS-1:0] new_value_reg, new_value_next;
    logic [TAG_BITS-1:0]   new_tag_reg, new_tag_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    status_t               rsp_status_reg, rsp_status_next;
    logic [VALUE_BITS-1:0] rsp_value_reg, rsp_value_next;
    logic [TAG_BITS-1:0]   rsp_tag_reg, rsp_tag_next;
    logic [CNT_W-1:0]      rsp_count_reg, rsp_count_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [VALUE_BITS-1:0] rd_value;
    logic [TAG_BITS-1:0]   rd_tag;
    logic                  rsp_free;
    logic                  rsp_load;
    logic                  req_fire;

    // entry store: {value, tag} per slot, ring ordered from head (largest)
    spq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_value = ram_rdata[ENTRY_W-1 -: VALUE_BITS];
    assign rd_tag   = ram_rdata[TAG_BITS-1:0];

    // handshake
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && rsp_free;
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.out_value   = rsp_value_reg;
    assign rsp.out_tag     = rsp_tag_reg;
    assign rsp.count_after = rsp_count_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            remaining_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            remaining_reg <= remaining_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_ptr_reg     <= rd_ptr_next;
        new_value_reg  <= new_value_next;
        new_tag_reg    <= new_tag_next;
        rsp_status_reg <= rsp_status_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_tag_reg    <= rsp_tag_next;
        rsp_count_reg  <= rsp_count_next;
    end

    // sequencer: next state, RAM access and response load
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        rd_ptr_next     = rd_ptr_reg;
        remaining_next  = remaining_reg;
        new_value_next  = new_value_reg;
        new_tag_next    = new_tag_reg;
        rsp_load        = 1'b0;
        rsp_status_next = rsp_status_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_tag_next    = rsp_tag_reg;
        rsp_count_next  = rsp_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_reg;
        ram_wdata       = {new_value_reg, new_tag_reg};
        ram_raddr       = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.kind == KIND_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_load        = 1'b1;
                            rsp_status_next = ST_EMPTY;
                            rsp_value_next  = '0;
                            rsp_tag_next    = '0;
                            rsp_count_next  = count_reg;
                        end
                        else
                        begin
                            // fetch the head entry
                            ram_raddr  = head_reg;
                            state_next = S_POP;
                        end
                    end
                    else if (count_reg == FULL_CNT)
                    begin
                        rsp_load        = 1'b1;
                        rsp_status_next = ST_FULL;
                        rsp_value_next  = '0;
                        rsp_tag_next    = '0;
                        rsp_count_next  = count_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty queue: the entry goes straight in
                        ram_we          = 1'b1;
                        ram_waddr       = tail_reg;
                        ram_wdata       = {req.entry_value, req.entry_tag};
                        tail_next       = ptr_inc(tail_reg);
                        count_next      = ONE_CNT;
                        rsp_load        = 1'b1;
                        rsp_status_next = ST_INSERTED;
                        rsp_value_next  = '0;
                        rsp_tag_next    = '0;
                        rsp_count_next  = ONE_CNT;
                    end
                    else
                    begin
                        // start the walk at the last stored entry
                        new_value_next = req.entry_value;
                        new_tag_next   = req.entry_tag;
                        rd_ptr_next    = ptr_dec(tail_reg);
                        ram_raddr      = ptr_dec(tail_reg);
                        remaining_next = count_reg;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                ram_raddr = rd_ptr_reg;
                if (rd_value <= new_value_reg)
                begin
                    // entry moves one slot toward the tail
                    ram_we    = 1'b1;
                    ram_waddr = ptr_inc(rd_ptr_reg);
                    ram_wdata = ram_rdata;
                    if (remaining_reg == ONE_CNT)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        rd_ptr_next    = ptr_dec(rd_ptr_reg);
                        ram_raddr      = ptr_dec(rd_ptr_reg);
                        remaining_next = remaining_reg - ONE_CNT;
                    end
                end
                else if (rsp_free)
                begin
                    // larger entry found: new one lands just behind it
                    ram_we          = 1'b1;
                    ram_waddr       = ptr_inc(rd_ptr_reg);
                    tail_next       = ptr_inc(tail_reg);
                    count_next      = count_reg + ONE_CNT;
                    rsp_load        = 1'b1;
                    rsp_status_next = ST_INSERTED;
                    rsp_value_next  = '0;
                    rsp_tag_next    = '0;
                    rsp_count_next  = count_reg + ONE_CNT;
                    state_next      = S_IDLE;
                end
            end

            S_PUT:
            begin
                // new entry becomes the head
                if (rsp_free)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = rd_ptr_reg;
                    tail_next       = ptr_inc(tail_reg);
                    count_next      = count_reg + ONE_CNT;
                    rsp_load        = 1'b1;
                    rsp_status_next = ST_INSERTED;
                    rsp_value_next  = '0;
                    rsp_tag_next    = '0;
                    rsp_count_next  = count_reg + ONE_CNT;
                    state_next      = S_IDLE;
                end
            end

            S_POP:
            begin
                // head read stays on the port while the response slot is busy
                ram_raddr = head_reg;
                if (rsp_free)
                begin
                    head_next       = ptr_inc(head_reg);
                    count_next      = count_reg - ONE_CNT;
                    rsp_load        = 1'b1;
                    rsp_status_next = ST_POPPED;
                    rsp_value_next  = rd_value;
                    rsp_tag_next    = rd_tag;
                    rsp_count_next  = count_reg - ONE_CNT;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // response valid
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

`ifndef SYNTHESIS
    // occupancy never exceeds the capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above capacity");

    // ring pointers meet when empty or full
    a_ring_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> (tail_reg == head_reg))
        else $error("head and tail disagree with entry count");

    // the walk never runs past the stored entries
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (remaining_reg != '0 && remaining_reg <= count_reg))
        else $error("insert walk out of range");

    // every request either answers at once or starts a RAM sequence
    a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != S_IDLE || rsp_valid_reg))
        else $error("request accepted without response or work");
`endif

endmodule

`default_nettype wire
